>>> sv/text_terminal_cursor_engine_top_assert.svh
// Assertion macros for the text terminal cursor engine.
// Needs a clk and an active-low arst_n in the scope of each use.
`ifndef TEXT_TERMINAL_CURSOR_ENGINE_TOP_ASSERT_SVH
`define TEXT_TERMINAL_CURSOR_ENGINE_TOP_ASSERT_SVH

// same-cycle implication, idle during reset
`define TTCE_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, idle during reset
`define TTCE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/ttce_pkg.sv
// Shared types, constants and the microcode table of the cursor engine.
// No dependencies; used by ttce_seq and text_terminal_cursor_engine_top.
package ttce_pkg;

	localparam int TabWidth = 8;
	localparam int MaxRows  = 60;

	localparam logic [7:0] CharNul   = 8'h00;
	localparam logic [7:0] CharBel   = 8'h07;
	localparam logic [7:0] CharBs    = 8'h08;
	localparam logic [7:0] CharTab   = 8'h09;
	localparam logic [7:0] CharLf    = 8'h0A;
	localparam logic [7:0] CharFf    = 8'h0C;
	localparam logic [7:0] CharCr    = 8'h0D;
	localparam logic [7:0] CharSpace = 8'h20;

	typedef enum logic [1:0] {
		REG_COLUMNS   = 2'd0,
		REG_ROWS      = 2'd1,
		REG_ATTRIBUTE = 2'd2,
		REG_CURSOR_EN = 2'd3
	} reg_t;

	typedef enum logic [1:0] {
		RES_REPORT = 2'd0,
		RES_CELL   = 2'd1,
		RES_SCROLL = 2'd2,
		RES_BELL   = 2'd3
	} res_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_GOTO,
		OP_BACK,
		OP_CR,
		OP_STORE,
		OP_LF,
		OP_HOME,
		OP_TABCNT,
		OP_FFCNT
	} op_t;

	typedef enum logic [2:0] {
		UE_NONE,
		UE_CELL,
		UE_SCROLL,
		UE_BELL,
		UE_REPORT
	} uev_t;

	typedef enum logic [1:0] {
		J_WAIT,
		J_NEXT,
		J_JMP,
		J_LOOP
	} cond_t;

	typedef logic [3:0] pc_t;

	localparam pc_t StIdle   = 4'd0;
	localparam pc_t StGoto   = 4'd1;
	localparam pc_t StBel    = 4'd2;
	localparam pc_t StBs     = 4'd3;
	localparam pc_t StCr     = 4'd4;
	localparam pc_t StFf     = 4'd5;
	localparam pc_t StFLoop  = 4'd6;
	localparam pc_t StFScr   = 4'd7;
	localparam pc_t StHome   = 4'd8;
	localparam pc_t StChar   = 4'd9;
	localparam pc_t StLf     = 4'd10;
	localparam pc_t StScr    = 4'd11;
	localparam pc_t StTab    = 4'd12;
	localparam pc_t StTLoop  = 4'd13;
	localparam pc_t StTScr   = 4'd14;
	localparam pc_t StReport = 4'd15;

	typedef struct packed {
		op_t   op;
		uev_t  ev;
		logic  space;
		logic  dec;
		cond_t cond;
		pc_t   target;
	} ctrl_t;

	// status from the datapath into the sequencer
	typedef struct packed {
		logic in_valid;
		logic slot_free;
		logic cnt_nz;
		logic pend;
		pc_t  entry;
	} stat_t;

	// sequencer to datapath
	typedef struct packed {
		ctrl_t word;
		logic  go;
		logic  emit;
		pc_t   pc;
	} seq_t;

	function automatic ctrl_t ucode(input pc_t pc);
		ctrl_t w;
		case (pc)
			StIdle:   w = '{OP_LOAD,   UE_NONE,   1'b0, 1'b0, J_WAIT, StIdle};
			StGoto:   w = '{OP_GOTO,   UE_NONE,   1'b0, 1'b0, J_JMP,  StReport};
			StBel:    w = '{OP_NONE,   UE_BELL,   1'b0, 1'b0, J_JMP,  StReport};
			StBs:     w = '{OP_BACK,   UE_NONE,   1'b0, 1'b0, J_JMP,  StReport};
			StCr:     w = '{OP_CR,     UE_NONE,   1'b0, 1'b0, J_JMP,  StReport};
			StFf:     w = '{OP_FFCNT,  UE_NONE,   1'b0, 1'b0, J_NEXT, StIdle};
			StFLoop:  w = '{OP_LF,     UE_NONE,   1'b0, 1'b1, J_NEXT, StIdle};
			StFScr:   w = '{OP_NONE,   UE_SCROLL, 1'b0, 1'b0, J_LOOP, StFLoop};
			StHome:   w = '{OP_HOME,   UE_NONE,   1'b0, 1'b0, J_JMP,  StReport};
			StChar:   w = '{OP_STORE,  UE_CELL,   1'b0, 1'b0, J_JMP,  StScr};
			StLf:     w = '{OP_LF,     UE_NONE,   1'b0, 1'b0, J_NEXT, StIdle};
			StScr:    w = '{OP_NONE,   UE_SCROLL, 1'b0, 1'b0, J_JMP,  StReport};
			StTab:    w = '{OP_TABCNT, UE_NONE,   1'b0, 1'b0, J_NEXT, StIdle};
			StTLoop:  w = '{OP_STORE,  UE_CELL,   1'b1, 1'b1, J_NEXT, StIdle};
			StTScr:   w = '{OP_NONE,   UE_SCROLL, 1'b0, 1'b0, J_LOOP, StTLoop};
			StReport: w = '{OP_NONE,   UE_REPORT, 1'b0, 1'b0, J_JMP,  StIdle};
			default:  w = '{OP_NONE,   UE_NONE,   1'b0, 1'b0, J_JMP,  StIdle};
		endcase
		return w;
	endfunction

	// first microcode step for a request
	function automatic pc_t entry_of(input logic req_type, input logic [7:0] code);
		pc_t e;
		if (req_type) begin
			e = StGoto;
		end else begin
			case (code)
				CharNul: e = StReport;
				CharBel: e = StBel;
				CharBs:  e = StBs;
				CharTab: e = StTab;
				CharLf:  e = StLf;
				CharFf:  e = StFf;
				CharCr:  e = StCr;
				default: e = StChar;
			endcase
		end
		return e;
	endfunction

endpackage

>>> sv/ttce_seq.sv
// Microcode sequencer: step counter, control table lookup and jumps.
// Depends on ttce_pkg for the control word and the table.
module ttce_seq (
	input  logic           clk,
	input  logic           arst_n,
	input  ttce_pkg::stat_t stat,
	output ttce_pkg::seq_t  ctl
);

	ttce_pkg::pc_t   pc_q;
	ttce_pkg::pc_t   pc_nx;
	ttce_pkg::ctrl_t word;
	logic            need;
	logic            go;

	always_comb begin
		word = ttce_pkg::ucode(pc_q);
		need = (word.ev == ttce_pkg::UE_CELL) || (word.ev == ttce_pkg::UE_BELL) ||
		       (word.ev == ttce_pkg::UE_REPORT) ||
		       ((word.ev == ttce_pkg::UE_SCROLL) && stat.pend);
		if (word.cond == ttce_pkg::J_WAIT) begin
			go = stat.in_valid;
		end else begin
			go = !need || stat.slot_free;
		end
		case (word.cond)
			ttce_pkg::J_WAIT: pc_nx = stat.entry;
			ttce_pkg::J_NEXT: pc_nx = pc_q + 4'd1;
			ttce_pkg::J_JMP:  pc_nx = word.target;
			ttce_pkg::J_LOOP: pc_nx = stat.cnt_nz ? word.target : pc_q + 4'd1;
			default:          pc_nx = ttce_pkg::StIdle;
		endcase
		ctl.word = word;
		ctl.go   = go;
		ctl.emit = go && need;
		ctl.pc   = pc_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= ttce_pkg::StIdle;
		end else if (go) begin
			pc_q <= pc_nx;
		end
	end

endmodule

>>> sv/text_terminal_cursor_engine_top.sv
// Top level of the text terminal cursor engine: config registers, datapath, output word.
// Depends on ttce_pkg, ttce_seq and text_terminal_cursor_engine_top_assert.svh.
//
//  channel | handshake            | word
//  --------+----------------------+------------------------------------------------
//  in      | in_valid / in_ready  | req_type, char_code, goto_col, goto_row
//  out     | out_valid / out_ready| event_res, cell_*, report_col, cursor_row,
//          |                      | cursor_shown, last
//  cfg     | cfg_we (no wait)     | cfg_idx, cfg_data
//
// One request at a time, run by the microcode sequencer, one table step per cycle while
// no stall or wait for input holds it, and at most one output word per step. A goto
// runs its goto and report steps, a tab or form feed one loop pass per space or line.
// Any stall on out holds the sequencer on its emitting step. Reset clears the cursor
// to the bottom-left corner and restores 80 columns, 24 rows, attribute 7 and a hidden cursor.
`include "text_terminal_cursor_engine_top_assert.svh"

module text_terminal_cursor_engine_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_idx,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        req_type,
	input  logic [7:0]  char_code,
	input  logic [7:0]  goto_col,
	input  logic [7:0]  goto_row,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  event_res,
	output logic [7:0]  cell_col,
	output logic [5:0]  cell_row,
	output logic [7:0]  cell_char,
	output logic [15:0] cell_attr,
	output logic [7:0]  report_col,
	output logic [5:0]  cursor_row,
	output logic        cursor_shown,
	output logic        last
);

	// configuration registers
	logic [7:0]  cols_q;
	logic [5:0]  rows_q;
	logic [15:0] attr_q;
	logic        cen_q;

	// cursor, loop count, pending scroll and latched request
	logic [7:0]  x_q;
	logic [5:0]  y_q;
	logic [5:0]  cnt_q;
	logic        pend_q;
	logic [7:0]  ch_q;
	logic [7:0]  gc_q;
	logic [7:0]  gr_q;

	// output word
	logic        ov_q;
	logic [1:0]  ev_q;
	logic [7:0]  ccol_q;
	logic [5:0]  crow_q;
	logic [7:0]  cchar_q;
	logic [15:0] cattr_q;
	logic [7:0]  kcol_q;
	logic [5:0]  krow_q;
	logic        kshow_q;
	logic        last_q;

	ttce_pkg::stat_t stat;
	ttce_pkg::seq_t  ctl;

	logic [7:0] tw;
	logic [7:0] twm1;
	logic [5:0] th;
	logic [5:0] thm1;
	logic [8:0] x_inc;
	logic       at_edge;
	logic [5:0] gr_c;
	logic       accept;

	// effective screen size: zero acts as one, rows saturate at the maximum
	always_comb begin
		tw = (cols_q == 8'd0) ? 8'd1 : cols_q;
		twm1 = tw - 8'd1;
		if (rows_q == 6'd0) begin
			th = 6'd1;
		end else if (rows_q > 6'(ttce_pkg::MaxRows)) begin
			th = 6'(ttce_pkg::MaxRows);
		end else begin
			th = rows_q;
		end
		thm1 = th - 6'd1;
		x_inc = {1'b0, x_q} + 9'd1;
		at_edge = x_inc >= {1'b0, tw};
		gr_c = (gr_q > {2'b00, thm1}) ? thm1 : gr_q[5:0];
	end

	assign in_ready = (ctl.pc == ttce_pkg::StIdle);
	assign accept   = in_valid && in_ready;

	always_comb begin
		stat.in_valid  = in_valid;
		stat.slot_free = !ov_q || out_ready;
		stat.cnt_nz    = (cnt_q != 6'd0);
		stat.pend      = pend_q;
		stat.entry     = ttce_pkg::entry_of(req_type, char_code);
	end

	ttce_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctl    (ctl)
	);

	// configuration writes; an unknown index never occurs with a two-bit index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q <= 8'd80;
			rows_q <= 6'd24;
			attr_q <= 16'd7;
			cen_q  <= 1'b0;
		end else if (cfg_we) begin
			case (ttce_pkg::reg_t'(cfg_idx))
				ttce_pkg::REG_COLUMNS:   cols_q <= cfg_data[7:0];
				ttce_pkg::REG_ROWS:      rows_q <= cfg_data[5:0];
				ttce_pkg::REG_ATTRIBUTE: attr_q <= cfg_data;
				ttce_pkg::REG_CURSOR_EN: cen_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// request latch: taken once, held for the whole request
	always_ff @(posedge clk) begin
		if (accept) begin
			ch_q <= char_code;
			gc_q <= goto_col;
			gr_q <= goto_row;
		end
	end

	// cursor datapath, one micro-operation per step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q    <= 8'd0;
			y_q    <= 6'd0;
			cnt_q  <= 6'd0;
			pend_q <= 1'b0;
		end else if (ctl.go) begin
			if (ctl.word.dec) begin
				cnt_q <= cnt_q - 6'd1;
			end
			// a scroll step always consumes the pending flag
			if (ctl.word.ev == ttce_pkg::UE_SCROLL) begin
				pend_q <= 1'b0;
			end
			case (ctl.word.op)
				ttce_pkg::OP_LOAD: begin
					// saturate a cursor left outside a shrunken screen
					x_q <= (x_q > twm1) ? twm1 : x_q;
					y_q <= (y_q > thm1) ? thm1 : y_q;
				end
				ttce_pkg::OP_GOTO: begin
					x_q <= (gc_q > twm1) ? twm1 : gc_q;
					y_q <= thm1 - gr_c;
				end
				ttce_pkg::OP_BACK: begin
					// at the left edge climb to the end of the line above, or stick on top
					if (x_q != 8'd0) begin
						x_q <= x_q - 8'd1;
					end else if (y_q < thm1) begin
						x_q <= twm1;
						y_q <= y_q + 6'd1;
					end
				end
				ttce_pkg::OP_CR: x_q <= 8'd0;
				ttce_pkg::OP_STORE: begin
					if (at_edge) begin
						x_q <= 8'd0;
						if (y_q == 6'd0) begin
							pend_q <= 1'b1;
						end else begin
							y_q <= y_q - 6'd1;
						end
					end else begin
						x_q <= x_inc[7:0];
					end
				end
				ttce_pkg::OP_LF: begin
					x_q <= 8'd0;
					if (y_q == 6'd0) begin
						pend_q <= 1'b1;
					end else begin
						y_q <= y_q - 6'd1;
					end
				end
				ttce_pkg::OP_HOME: begin
					x_q <= 8'd0;
					y_q <= thm1;
				end
				ttce_pkg::OP_TABCNT:
					cnt_q <= 6'(ttce_pkg::TabWidth - int'(x_q) % ttce_pkg::TabWidth);
				ttce_pkg::OP_FFCNT: cnt_q <= th + 6'd1;
				default: ;
			endcase
		end
	end

	// output word valid: set on emit, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (ctl.emit) begin
			ov_q <= 1'b1;
		end else if (out_ready) begin
			ov_q <= 1'b0;
		end
	end

	// output word payload; unused fields are zero
	always_ff @(posedge clk) begin
		if (ctl.emit) begin
			ev_q    <= ttce_pkg::RES_REPORT;
			ccol_q  <= 8'd0;
			crow_q  <= 6'd0;
			cchar_q <= 8'd0;
			cattr_q <= 16'd0;
			kcol_q  <= 8'd0;
			krow_q  <= 6'd0;
			kshow_q <= 1'b0;
			last_q  <= 1'b0;
			case (ctl.word.ev)
				ttce_pkg::UE_CELL: begin
					ev_q    <= ttce_pkg::RES_CELL;
					ccol_q  <= x_q;
					crow_q  <= y_q;
					cchar_q <= ctl.word.space ? ttce_pkg::CharSpace : ch_q;
					cattr_q <= attr_q;
				end
				ttce_pkg::UE_SCROLL: ev_q <= ttce_pkg::RES_SCROLL;
				ttce_pkg::UE_BELL:   ev_q <= ttce_pkg::RES_BELL;
				ttce_pkg::UE_REPORT: begin
					kcol_q  <= x_q;
					krow_q  <= y_q;
					kshow_q <= cen_q;
					last_q  <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	assign out_valid    = ov_q;
	assign event_res    = ev_q;
	assign cell_col     = ccol_q;
	assign cell_row     = crow_q;
	assign cell_char    = cchar_q;
	assign cell_attr    = cattr_q;
	assign report_col   = kcol_q;
	assign cursor_row   = krow_q;
	assign cursor_shown = kshow_q;
	assign last         = last_q;

	// a taken request always leaves the idle step
	`TTCE_ASSERT_NEXT(a_accept_leaves_idle, accept, !in_ready, "request accepted but sequencer still idle")
	// only the cursor report closes a request
	`TTCE_ASSERT_NOW(a_last_is_report, ov_q && last_q, ev_q == ttce_pkg::RES_REPORT, "last set on a non-report word")
	// a pending scroll only ever waits on a scroll step
	`TTCE_ASSERT_NOW(a_pend_on_scroll, pend_q, (ctl.pc == ttce_pkg::StScr) || (ctl.pc == ttce_pkg::StFScr) || (ctl.pc == ttce_pkg::StTScr), "scroll pending outside a scroll step")

endmodule

>>> verif/ttce_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the text terminal cursor engine: tracks the registers, predicts output words.
// Depends on ttce_pkg; instantiated beside the block by tb_text_terminal_cursor_engine_top.
module ttce_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_idx,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic        req_type,
	input  logic [7:0]  char_code,
	input  logic [7:0]  goto_col,
	input  logic [7:0]  goto_row,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [1:0]  event_res,
	input  logic [7:0]  cell_col,
	input  logic [5:0]  cell_row,
	input  logic [7:0]  cell_char,
	input  logic [15:0] cell_attr,
	input  logic [7:0]  report_col,
	input  logic [5:0]  cursor_row,
	input  logic        cursor_shown,
	input  logic        last,
	output int          word_errors,
	output int          words_waiting
);

	typedef struct packed {
		ttce_pkg::res_t ev;
		logic [7:0]     cell_c;
		logic [5:0]     cell_r;
		logic [7:0]     cell_ch;
		logic [15:0]    cell_at;
		logic [7:0]     curs_c;
		logic [5:0]     curs_r;
		logic           shown;
		logic           fin;
	} term_word_t;

	logic [7:0]  screen_cols;
	logic [5:0]  screen_rows;
	logic [15:0] cell_attribute;
	logic        cursor_on;
	logic [7:0]  cur_col;
	logic [5:0]  cur_line;

	term_word_t  expected_words[$];
	term_word_t  want;

	function automatic term_word_t blank_word(input ttce_pkg::res_t ev);
		term_word_t w;
		w = '0;
		w.ev = ev;
		return w;
	endfunction

	function automatic void check_field(input string name, input int unsigned exp_v,
			input int unsigned act_v);
		if (exp_v != act_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, act_v);
			word_errors++;
		end
	endfunction

	// wrap the cursor back onto the screen, scrolling while it sits below the bottom line
	task automatic settle(inout int x, inout int y, input int tw, input int th);
		if (x < 0) begin
			if (y >= th - 1) begin
				x = 0;
			end else begin
				x = tw - 1;
				y++;
			end
		end
		if (y >= th)
			y = th - 1;
		if (x >= tw) begin
			x = 0;
			y--;
		end
		while (y < 0) begin
			expected_words.push_back(blank_word(ttce_pkg::RES_SCROLL));
			y++;
		end
	endtask

	task automatic put_cell(inout int x, inout int y, input int tw, input int th,
			input logic [7:0] ch);
		term_word_t w;
		w = blank_word(ttce_pkg::RES_CELL);
		w.cell_c  = x[7:0];
		w.cell_r  = y[5:0];
		w.cell_ch = ch;
		w.cell_at = cell_attribute;
		expected_words.push_back(w);
		x++;
		settle(x, y, tw, th);
	endtask

	task automatic feed_line(inout int x, inout int y, input int tw, input int th);
		x = 0;
		y--;
		settle(x, y, tw, th);
	endtask

	task automatic expand_request(input logic rt, input logic [7:0] code,
			input logic [7:0] gc, input logic [7:0] gr);
		int tw, th, x, y, tx, ty;
		term_word_t rep;
		tw = (screen_cols == 0) ? 1 : int'(screen_cols);
		th = (screen_rows == 0) ? 1 : int'(screen_rows);
		if (th > ttce_pkg::MaxRows)
			th = ttce_pkg::MaxRows;
		x = cur_col;
		y = cur_line;
		// pull the cursor inside a screen that shrank since the last word
		if (x > tw - 1)
			x = tw - 1;
		if (y > th - 1)
			y = th - 1;
		if (rt) begin
			tx = gc;
			ty = gr;
			if (tx > tw - 1)
				tx = tw - 1;
			if (ty > th - 1)
				ty = th - 1;
			x = tx;
			y = th - 1 - ty;
		end else begin
			case (code)
				ttce_pkg::CharNul: ;
				ttce_pkg::CharBel: expected_words.push_back(blank_word(ttce_pkg::RES_BELL));
				ttce_pkg::CharBs: begin
					x--;
					settle(x, y, tw, th);
				end
				ttce_pkg::CharTab:
					repeat (ttce_pkg::TabWidth - (x % ttce_pkg::TabWidth))
						put_cell(x, y, tw, th, ttce_pkg::CharSpace);
				ttce_pkg::CharLf:  feed_line(x, y, tw, th);
				ttce_pkg::CharFf: begin
					repeat (th + 1) feed_line(x, y, tw, th);
					x = 0;
					y = th - 1;
				end
				ttce_pkg::CharCr:  x = 0;
				default: put_cell(x, y, tw, th, code);
			endcase
		end
		cur_col  = x[7:0];
		cur_line = y[5:0];
		rep = blank_word(ttce_pkg::RES_REPORT);
		rep.curs_c = x[7:0];
		rep.curs_r = y[5:0];
		rep.shown  = cursor_on;
		rep.fin    = 1'b1;
		expected_words.push_back(rep);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_cols    = 8'd80;
			screen_rows    = 6'd24;
			cell_attribute = 16'd7;
			cursor_on      = 1'b0;
			cur_col        = '0;
			cur_line       = '0;
			expected_words.delete();
			word_errors    = 0;
			words_waiting  = 0;
		end else begin
			if (cfg_we) begin
				case (ttce_pkg::reg_t'(cfg_idx))
					ttce_pkg::REG_COLUMNS:   screen_cols    = cfg_data[7:0];
					ttce_pkg::REG_ROWS:      screen_rows    = cfg_data[5:0];
					ttce_pkg::REG_ATTRIBUTE: cell_attribute = cfg_data;
					ttce_pkg::REG_CURSOR_EN: cursor_on      = cfg_data[0];
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				expand_request(req_type, char_code, goto_col, goto_row);
			if (out_valid && out_ready) begin
				if (expected_words.size() == 0) begin
					$error("output word with nothing expected: event_res %0d", event_res);
					word_errors++;
				end else begin
					want = expected_words.pop_front();
					check_field("event_res", want.ev, event_res);
					check_field("cell_col", want.cell_c, cell_col);
					check_field("cell_row", want.cell_r, cell_row);
					check_field("cell_char", want.cell_ch, cell_char);
					check_field("cell_attr", want.cell_at, cell_attr);
					check_field("report_col", want.curs_c, report_col);
					check_field("cursor_row", want.curs_r, cursor_row);
					check_field("cursor_shown", want.shown, cursor_shown);
					check_field("last", want.fin, last);
				end
			end
			words_waiting = expected_words.size();
		end
	end

endmodule

>>> verif/tb_text_terminal_cursor_engine_top.sv
`timescale 1ns / 100ps
// Testbench top for the text terminal cursor engine: clock, reset, stimulus and verdict.
// Depends on ttce_pkg, text_terminal_cursor_engine_top and the ttce_checker scoreboard.
module tb_text_terminal_cursor_engine_top;

	// Longest honest quiet spell: the longest receiver stall or sender gap from pick_gap,
	// plus a handful of microcode steps. StallLimit lies far above it.
	localparam int StallLimit  = 5000;
	// Cycles to let pass after the last expected word before touching the registers.
	localparam int DrainCycles = 16;
	localparam int Phases      = 10;
	localparam int PhaseWords  = 31;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_idx;
	logic [15:0] cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic        req_type;
	logic [7:0]  char_code;
	logic [7:0]  goto_col;
	logic [7:0]  goto_row;
	logic        out_valid;
	logic        out_ready;
	logic [1:0]  event_res;
	logic [7:0]  cell_col;
	logic [5:0]  cell_row;
	logic [7:0]  cell_char;
	logic [15:0] cell_attr;
	logic [7:0]  report_col;
	logic [5:0]  cursor_row;
	logic        cursor_shown;
	logic        last;

	int          word_errors;
	int          words_waiting;
	int          quiet_cycles;
	// when set, neither side idles: back-to-back words on both channels
	logic        calm;

	text_terminal_cursor_engine_top DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_idx      (cfg_idx),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.req_type     (req_type),
		.char_code    (char_code),
		.goto_col     (goto_col),
		.goto_row     (goto_row),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.event_res    (event_res),
		.cell_col     (cell_col),
		.cell_row     (cell_row),
		.cell_char    (cell_char),
		.cell_attr    (cell_attr),
		.report_col   (report_col),
		.cursor_row   (cursor_row),
		.cursor_shown (cursor_shown),
		.last         (last)
	);

	ttce_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_idx       (cfg_idx),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.req_type      (req_type),
		.char_code     (char_code),
		.goto_col      (goto_col),
		.goto_row      (goto_row),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.event_res     (event_res),
		.cell_col      (cell_col),
		.cell_row      (cell_row),
		.cell_char     (cell_char),
		.cell_attr     (cell_attr),
		.report_col    (report_col),
		.cursor_row    (cursor_row),
		.cursor_shown  (cursor_shown),
		.last          (last),
		.word_errors   (word_errors),
		.words_waiting (words_waiting)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Idle length for either side: mostly none or a few cycles, now and then a long one.
	function automatic int pick_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Receiver: drop ready for a random spell, then hold it high for a random run.
	// At most one assignment to out_ready per falling edge.
	initial begin
		int gap;
		out_ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			gap = pick_gap();
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 10)) @(negedge clk);
		end
	end

	// Watchdog: count cycles where neither channel moves a word.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= StallLimit) begin
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	// Offer one request word, called at a falling edge; returns at the falling edge after
	// acceptance so the next word can follow with no bubble.
	task automatic send_word(input logic rt, input logic [7:0] code, input logic [7:0] gc,
			input logic [7:0] gr);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid  <= 1'b1;
		req_type  <= rt;
		char_code <= code;
		goto_col  <= gc;
		goto_row  <= gr;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
	endtask

	// Put a character; the goto fields carry junk, which the block must ignore.
	task automatic send_char(input logic [7:0] code);
		send_word(1'b0, code, 8'($urandom), 8'($urandom));
	endtask

	// Goto with a junk character code.
	task automatic send_goto(input logic [7:0] gc, input logic [7:0] gr);
		send_word(1'b1, 8'($urandom), gc, gr);
	endtask

	// Hold the sender off until every expected word is back, then let the block go quiet.
	task automatic drain_out();
		in_valid <= 1'b0;
		while (words_waiting != 0) @(negedge clk);
		repeat (DrainCycles) @(negedge clk);
	endtask

	// Write all four registers back to back, junk in the unused upper data bits.
	task automatic set_screen(input logic [7:0] cols, input logic [5:0] nrows,
			input logic [15:0] attr, input logic cur_en);
		cfg_we   <= 1'b1;
		cfg_idx  <= ttce_pkg::REG_COLUMNS;
		cfg_data <= {8'($urandom), cols};
		@(negedge clk);
		cfg_idx  <= ttce_pkg::REG_ROWS;
		cfg_data <= {10'($urandom), nrows};
		@(negedge clk);
		cfg_idx  <= ttce_pkg::REG_ATTRIBUTE;
		cfg_data <= attr;
		@(negedge clk);
		cfg_idx  <= ttce_pkg::REG_CURSOR_EN;
		cfg_data <= {15'($urandom), cur_en};
		@(negedge clk);
		cfg_we   <= 1'b0;
		@(negedge clk);
	endtask

	// One random request word: mostly characters, a share of control codes and gotos.
	task automatic send_random();
		int r;
		logic [7:0] ctl[6];
		ctl = '{ttce_pkg::CharNul, ttce_pkg::CharBel, ttce_pkg::CharBs, ttce_pkg::CharTab,
			ttce_pkg::CharLf, ttce_pkg::CharCr};
		r = $urandom_range(0, 99);
		if (r < 45)
			send_char(8'($urandom));
		else if (r < 65)
			send_char(ctl[$urandom_range(0, 5)]);
		else if (r < 69)
			send_char(ttce_pkg::CharFf);
		else if (r < 85)
			send_goto(8'($urandom_range(0, 24)), 8'($urandom_range(0, 12)));
		else
			send_goto(8'($urandom), 8'($urandom));
	endtask

	initial begin
		cfg_we    = 1'b0;
		cfg_idx   = ttce_pkg::REG_COLUMNS;
		cfg_data  = '0;
		in_valid  = 1'b0;
		req_type  = 1'b0;
		char_code = '0;
		goto_col  = '0;
		goto_row  = '0;
		calm      = 1'b0;
		arst_n    = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part on the reset screen of 80 by 24.
		send_char(8'h41);
		send_char(ttce_pkg::CharBs);            // back to column 0
		send_char(ttce_pkg::CharBs);            // wrap to the end of the line above
		send_char(ttce_pkg::CharNul);
		send_char(ttce_pkg::CharBel);
		send_char(ttce_pkg::CharCr);
		send_char(ttce_pkg::CharLf);
		send_char(ttce_pkg::CharLf);            // line feed on the bottom line scrolls
		send_char(ttce_pkg::CharTab);
		send_char(8'hFF);
		send_char(8'h01);             // other control codes are stored as cells
		send_char(8'h7F);
		send_goto(8'hFF, 8'hFF);      // clamped to the bottom-right corner
		send_char(8'h5A);             // wrap off the last cell scrolls
		send_goto(8'h00, 8'h00);      // top-left
		send_char(ttce_pkg::CharBs);            // stays put on the top line
		send_goto(8'd77, 8'd23);
		send_char(ttce_pkg::CharTab);           // tab that wraps and scrolls
		send_char(ttce_pkg::CharFf);
		send_word(1'b1, 8'hFF, 8'h00, 8'hFF);
		send_goto(8'd70, 8'd0);
		drain_out();
		// Shrink the screen under the cursor: it must be pulled back inside.
		set_screen(8'd10, 6'd5, 16'h00A5, 1'b1);
		send_char(8'h78);
		send_char(ttce_pkg::CharBs);
		drain_out();

		// Random phases; the first few pin the register extremes.
		for (int p = 0; p < Phases; p++) begin
			case (p)
				0: set_screen(8'd1, 6'd1, 16'h0000, 1'b1);
				1: set_screen(8'd255, 6'd60, 16'hFFFF, 1'b0);
				2: set_screen(8'd0, 6'd0, 16'($urandom), 1'b1);
				3: set_screen(8'd255, 6'd63, 16'($urandom), 1'b1);
				default: begin
					if ($urandom_range(0, 3) == 0)
						set_screen(8'($urandom), 6'($urandom), 16'($urandom), 1'($urandom));
					else
						set_screen(8'($urandom_range(1, 20)), 6'($urandom_range(1, 8)),
							16'($urandom), 1'($urandom));
				end
			endcase
			// one stretch with no idling on either side
			calm = (p == 5);
			repeat (PhaseWords) send_random();
			drain_out();
			calm = 1'b0;
		end

		if (word_errors == 0 && words_waiting == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
